/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define AFGB_CHECK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define AFGB_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/afgb_pkg.sv */
`default_nettype none
package afgb_pkg;

    // command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_PULL  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_REJ = 2'd1;
    localparam logic [1:0] ST_ARC = 2'd2;
    localparam logic [1:0] ST_END = 2'd3;

    // emission phases
    localparam logic [1:0] PH_LOAD  = 2'd0;
    localparam logic [1:0] PH_ITEMS = 2'd1;
    localparam logic [1:0] PH_LOSS  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    // field widths
    localparam int unsigned NODE_W = 11;
    localparam int unsigned DEM_W  = 16;
    localparam int unsigned IDX_W  = 6;

endpackage
`default_nettype wire

/* rtl/arc_flow_graph_builder.sv */
`default_nettype none
// channel   direction  handshake              payload
// in        input      in_valid / in_stall    cmd, weight, demand
// out       output     out_valid / out_stall  status, arc_tail, arc_head, item_index, is_loss
// cfg       input      cfg_we                 cfg_wdata (capacity)
//
// add: one node per cycle over 0..CAP_MAX through the reachable and distance
//   memories; clear and reset: a clearing pass over the reachable memory, no
//   input taken meanwhile.
// pull: a scan of the tail marks item by item, then of the loss nodes, each
//   stopping at the next arc, then the emit state.
// one item at a time; a waiting result does not block the next transfer in.
module arc_flow_graph_builder
    import afgb_pkg::*;
#(
    parameter int unsigned CAP_MAX   = 1024,
    parameter int unsigned MAX_ITEMS = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [NODE_W-1:0] cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        cmd,
    input  wire logic [NODE_W-1:0] weight,
    input  wire logic [DEM_W-1:0]  demand,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             status,
    output logic [NODE_W-1:0]      arc_tail,
    output logic [NODE_W-1:0]      arc_head,
    output logic [IDX_W-1:0]       item_index,
    output logic                   is_loss
);

    localparam int unsigned NW   = $clog2(CAP_MAX + 1);
    localparam int unsigned IW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CNTW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned SW   = ((NW > NODE_W) ? NW : NODE_W) + 1;
    localparam int unsigned XW   = ((NW > DEM_W) ? NW : DEM_W) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD   = 4'd1;
    localparam logic [3:0] S_ADDF  = 4'd2;
    localparam logic [3:0] S_CLR   = 4'd3;
    localparam logic [3:0] S_PITEM = 4'd4;
    localparam logic [3:0] S_PCHK  = 4'd5;
    localparam logic [3:0] S_LOSS  = 4'd6;
    localparam logic [3:0] S_LCHK  = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    // memories
    logic          reach_mem [0:CAP_MAX];
    logic [NW:0]   dist_mem  [0:CAP_MAX];
    logic          mark_mem  [0:(MAX_ITEMS << NW) - 1];
    logic [NODE_W-1:0] wt_mem [0:MAX_ITEMS-1];

    logic              reach_we, reach_wd, reach_re, reach_q;
    logic [NW-1:0]     reach_wa, reach_ra;
    logic              dist_we, dist_re;
    logic [NW-1:0]     dist_wa, dist_ra;
    logic [NW:0]       dist_wd, dist_q;
    logic              mark_we, mark_wd, mark_re, mark_q;
    logic [IW+NW-1:0]  mark_wa, mark_ra;
    logic              wt_we, wt_re;
    logic [IW-1:0]     wt_wa, wt_ra;
    logic [NODE_W-1:0] wt_wd, wt_q;

    // control and payload registers
    logic [3:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [NODE_W-1:0] cap_reg, cap_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [CNTW-1:0]   ci_reg, ci_next;
    logic [NW:0]       cn_reg, cn_next;
    logic [NW-1:0]     last_reg, last_next;
    logic [NW-1:0]     t_reg, t_next;
    logic              pv_reg, pv_next;
    logic              clr_emit_reg, clr_emit_next;
    logic              out_valid_reg, out_valid_next;
    logic [NW-1:0]     pt_reg, pt_next;
    logic              plow_reg, plow_next;
    logic [NW:0]       fwd_reg, fwd_next;
    logic [NODE_W-1:0] w_reg, w_next;
    logic [DEM_W-1:0]  d_reg, d_next;
    logic [1:0]        rst_reg, rst_next;
    logic [NODE_W-1:0] rtail_reg, rtail_next, rhead_reg, rhead_next;
    logic [IDX_W-1:0]  ridx_reg, ridx_next;
    logic              rloss_reg, rloss_next;
    logic [1:0]        ost_reg, ost_next;
    logic [NODE_W-1:0] otail_reg, otail_next, ohead_reg, ohead_next;
    logic [IDX_W-1:0]  oidx_reg, oidx_next;
    logic              oloss_reg, oloss_next;

    // effective capacity, clamped to 1..CAP_MAX
    logic [SW-1:0] eff_cap;
    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = SW'(1);
        else if (SW'(cap_reg) > SW'(CAP_MAX))
            eff_cap = SW'(CAP_MAX);
        else
            eff_cap = SW'(cap_reg);
    end

    // add walk compute stage, one node behind the read issue
    logic [NW:0]   prev_dist, cur_dist;
    logic          prev_hit, cur_hit, p_in_cap, p_arc_fits;
    always_comb
    begin
        prev_dist  = (w_reg == NODE_W'(1)) ? fwd_reg : dist_q;
        prev_hit   = !plow_reg && !prev_dist[NW]
                     && (XW'(prev_dist[NW-1:0]) < XW'(d_reg));
        if (reach_q)
            cur_dist = '0;
        else if (plow_reg || prev_dist[NW])
            cur_dist = {1'b1, NW'(0)};
        else
            cur_dist = {1'b0, prev_dist[NW-1:0] + NW'(1)};
        cur_hit    = !cur_dist[NW] && (XW'(cur_dist[NW-1:0]) < XW'(d_reg));
        p_in_cap   = SW'(pt_reg) <= eff_cap;
        p_arc_fits = (SW'(pt_reg) + SW'(w_reg)) <= eff_cap;
    end

    logic [SW-1:0] item_head;
    assign item_head = SW'(cn_reg) + SW'(wt_q);

    // next state
    logic [1:0] pull_phase;
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cap_next       = cfg_we ? cfg_wdata : cap_reg;
        cnt_next       = cnt_reg;
        ci_next        = ci_reg;
        cn_next        = cn_reg;
        last_next      = last_reg;
        t_next         = t_reg;
        pv_next        = 1'b0;
        clr_emit_next  = clr_emit_reg;
        pt_next        = pt_reg;
        plow_next      = plow_reg;
        fwd_next       = fwd_reg;
        w_next         = w_reg;
        d_next         = d_reg;
        rst_next       = rst_reg;
        rtail_next     = rtail_reg;
        rhead_next     = rhead_reg;
        ridx_next      = ridx_reg;
        rloss_next     = rloss_reg;
        out_valid_next = out_valid_reg && out_stall;
        ost_next       = ost_reg;
        otail_next     = otail_reg;
        ohead_next     = ohead_reg;
        oidx_next      = oidx_reg;
        oloss_next     = oloss_reg;
        pull_phase     = phase_reg;

        reach_we = 1'b0; reach_wa = '0; reach_wd = 1'b0;
        reach_re = 1'b0; reach_ra = '0;
        dist_we  = 1'b0; dist_wa  = '0; dist_wd  = '0;
        dist_re  = 1'b0; dist_ra  = '0;
        mark_we  = 1'b0; mark_wa  = '0; mark_wd  = 1'b0;
        mark_re  = 1'b0; mark_ra  = '0;
        wt_we    = 1'b0; wt_wa    = '0; wt_wd    = '0;
        wt_re    = 1'b0; wt_ra    = '0;

        // write back of the add walk
        if (pv_reg)
        begin
            fwd_next = cur_dist;
            dist_we  = 1'b1;
            dist_wa  = pt_reg;
            dist_wd  = cur_dist;
            mark_we  = 1'b1;
            mark_wa  = {cnt_reg[IW-1:0], pt_reg};
            mark_wd  = cur_hit && p_arc_fits;
            reach_we = p_in_cap;
            reach_wa = pt_reg;
            reach_wd = reach_q || prev_hit;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rst_next   = ST_OK;
                    rtail_next = '0;
                    rhead_next = '0;
                    ridx_next  = '0;
                    rloss_next = 1'b0;
                    unique case (cmd)
                        CMD_ADD:
                        begin
                            if (weight == '0 || phase_reg != PH_LOAD
                                || cnt_reg >= CNTW'(MAX_ITEMS))
                            begin
                                rst_next   = ST_REJ;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                w_next     = weight;
                                d_next     = demand;
                                wt_we      = 1'b1;
                                wt_wa      = cnt_reg[IW-1:0];
                                wt_wd      = weight;
                                t_next     = '0;
                                state_next = S_ADD;
                            end
                        end
                        CMD_PULL:
                        begin
                            if (phase_reg == PH_LOAD)
                            begin
                                pull_phase = PH_ITEMS;
                                ci_next    = '0;
                                cn_next    = '0;
                            end
                            phase_next = pull_phase;
                            unique case (pull_phase)
                                PH_ITEMS: state_next = S_PITEM;
                                PH_LOSS:  state_next = S_LOSS;
                                default:
                                begin
                                    rst_next   = ST_END;
                                    state_next = S_EMIT;
                                end
                            endcase
                        end
                        CMD_CLEAR:
                        begin
                            phase_next    = PH_LOAD;
                            cnt_next      = '0;
                            ci_next       = '0;
                            cn_next       = '0;
                            last_next     = '0;
                            t_next        = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLR;
                        end
                        default:
                        begin
                            rst_next   = ST_REJ;
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            // issue reads for node t, compute follows next cycle
            S_ADD:
            begin
                reach_re  = 1'b1;
                reach_ra  = t_reg;
                dist_re   = 1'b1;
                dist_ra   = t_reg - NW'(w_reg);
                plow_next = SW'(t_reg) < SW'(w_reg);
                pt_next   = t_reg;
                pv_next   = 1'b1;
                if (t_reg == NW'(CAP_MAX))
                    state_next = S_ADDF;
                else
                    t_next = t_reg + NW'(1);
            end
            S_ADDF:
            begin
                cnt_next   = cnt_reg + CNTW'(1);
                rst_next   = ST_OK;
                state_next = S_EMIT;
            end
            // clearing pass over the reachable bitmap
            S_CLR:
            begin
                reach_we = 1'b1;
                reach_wa = t_reg;
                reach_wd = (t_reg == '0);
                if (t_reg == NW'(CAP_MAX))
                begin
                    clr_emit_next = 1'b0;
                    rst_next      = ST_OK;
                    state_next    = clr_emit_reg ? S_EMIT : S_IDLE;
                end
                else
                    t_next = t_reg + NW'(1);
            end
            S_PITEM:
            begin
                if (ci_reg >= cnt_reg)
                begin
                    phase_next = PH_LOSS;
                    cn_next    = (NW+1)'(1);
                    last_next  = '0;
                    state_next = S_LOSS;
                end
                else if (cn_reg > (NW+1)'(CAP_MAX))
                begin
                    ci_next = ci_reg + CNTW'(1);
                    cn_next = '0;
                end
                else
                begin
                    wt_re      = 1'b1;
                    wt_ra      = ci_reg[IW-1:0];
                    mark_re    = 1'b1;
                    mark_ra    = {ci_reg[IW-1:0], cn_reg[NW-1:0]};
                    state_next = S_PCHK;
                end
            end
            // check one tail mark of the current item
            S_PCHK:
            begin
                if (mark_q && item_head <= eff_cap)
                begin
                    rst_next   = ST_ARC;
                    rtail_next = NODE_W'(cn_reg);
                    rhead_next = NODE_W'(item_head);
                    ridx_next  = IDX_W'(ci_reg);
                    rloss_next = 1'b0;
                    cn_next    = cn_reg + (NW+1)'(1);
                    state_next = S_EMIT;
                end
                else if (cn_reg == (NW+1)'(CAP_MAX))
                begin
                    ci_next    = ci_reg + CNTW'(1);
                    cn_next    = '0;
                    state_next = S_PITEM;
                end
                else
                begin
                    cn_next = cn_reg + (NW+1)'(1);
                    mark_re = 1'b1;
                    mark_ra = {ci_reg[IW-1:0], cn_reg[NW-1:0] + NW'(1)};
                end
            end
            S_LOSS:
            begin
                if (SW'(cn_reg) <= eff_cap)
                begin
                    reach_re   = 1'b1;
                    reach_ra   = cn_reg[NW-1:0];
                    state_next = S_LCHK;
                end
                else
                begin
                    phase_next = PH_DONE;
                    rst_next   = ST_END;
                    state_next = S_EMIT;
                end
            end
            // loss arc between consecutive reachable loads
            S_LCHK:
            begin
                cn_next    = cn_reg + (NW+1)'(1);
                state_next = S_LOSS;
                if (reach_q)
                begin
                    last_next = cn_reg[NW-1:0];
                    if (last_reg != '0)
                    begin
                        rst_next   = ST_ARC;
                        rtail_next = NODE_W'(last_reg);
                        rhead_next = NODE_W'(cn_reg);
                        ridx_next  = '0;
                        rloss_next = 1'b1;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ost_next       = rst_reg;
                    otail_next     = rtail_reg;
                    ohead_next     = rhead_reg;
                    oidx_next      = ridx_reg;
                    oloss_next     = rloss_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            phase_reg     <= PH_LOAD;
            cap_reg       <= NODE_W'(1024);
            cnt_reg       <= '0;
            ci_reg        <= '0;
            cn_reg        <= '0;
            last_reg      <= '0;
            t_reg         <= '0;
            pv_reg        <= 1'b0;
            clr_emit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cap_reg       <= cap_next;
            cnt_reg       <= cnt_next;
            ci_reg        <= ci_next;
            cn_reg        <= cn_next;
            last_reg      <= last_next;
            t_reg         <= t_next;
            pv_reg        <= pv_next;
            clr_emit_reg  <= clr_emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pt_reg    <= pt_next;
        plow_reg  <= plow_next;
        fwd_reg   <= fwd_next;
        w_reg     <= w_next;
        d_reg     <= d_next;
        rst_reg   <= rst_next;
        rtail_reg <= rtail_next;
        rhead_reg <= rhead_next;
        ridx_reg  <= ridx_next;
        rloss_reg <= rloss_next;
        ost_reg   <= ost_next;
        otail_reg <= otail_next;
        ohead_reg <= ohead_next;
        oidx_reg  <= oidx_next;
        oloss_reg <= oloss_next;
    end

    // synchronous memories, registered read
    always_ff @(posedge clk)
    begin
        if (reach_we)
            reach_mem[reach_wa] <= reach_wd;
        if (reach_re)
            reach_q <= reach_mem[reach_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wa] <= dist_wd;
        if (dist_re)
            dist_q <= dist_mem[dist_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= mark_wd;
        if (mark_re)
            mark_q <= mark_mem[mark_ra];
    end

    always_ff @(posedge clk)
    begin
        if (wt_we)
            wt_mem[wt_wa] <= wt_wd;
        if (wt_re)
            wt_q <= wt_mem[wt_ra];
    end

    // ports
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = ost_reg;
    assign arc_tail   = otail_reg;
    assign arc_head   = ohead_reg;
    assign item_index = oidx_reg;
    assign is_loss    = oloss_reg;

`include "assert_macros.svh"

    `AFGB_CHECK(a_cnt_bound, cnt_reg <= CNTW'(MAX_ITEMS), "item count past table size")
    `AFGB_CHECK(a_walk_only_add, pv_reg |-> (state_reg == S_ADD || state_reg == S_ADDF), "stray write back")
    `AFGB_CHECK(a_walk_loading, (state_reg == S_ADD) |-> (phase_reg == PH_LOAD), "add walk after first pull")
    `AFGB_NEVER(a_arc_order, out_valid && status == ST_ARC && arc_head <= arc_tail, "arc head not above tail")

endmodule
`default_nettype wire

/* sim/arc_flow_graph_builder_tb.sv */
`timescale 1ns / 1ps

module arc_flow_graph_builder_tb;
    import afgb_pkg::*;

    localparam int unsigned NODES      = 1024;
    localparam int unsigned ITEM_SLOTS = 64;
    localparam logic [1:0]  CMD_BAD    = 2'd3;
    localparam int          IDLE_LIMIT = 400000;
    localparam int          HOLD_LEN   = 3000;

    typedef struct packed {
        logic [1:0]        status;
        logic [NODE_W-1:0] tail;
        logic [NODE_W-1:0] head;
        logic [IDX_W-1:0]  idx;
        logic              loss;
    } arc_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [NODE_W-1:0] cfg_wdata;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        cmd;
    logic [NODE_W-1:0] weight;
    logic [DEM_W-1:0]  demand;
    logic              out_valid;
    logic              out_stall;
    logic [1:0]        status;
    logic [NODE_W-1:0] arc_tail;
    logic [NODE_W-1:0] arc_head;
    logic [IDX_W-1:0]  item_index;
    logic              is_loss;

    arc_flow_graph_builder DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .weight(weight), .demand(demand),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .arc_tail(arc_tail), .arc_head(arc_head),
        .item_index(item_index), .is_loss(is_loss)
    );

    // predictor state
    logic [NODE_W-1:0] cap_reg;
    bit                reach [0:NODES];
    bit                marks [ITEM_SLOTS][0:NODES];
    int                wts [ITEM_SLOTS];
    int                n_items;
    logic [1:0]        phase;
    int                cur_item;
    int                cur_node;
    int                last_load;

    arc_result_t arc_expect_q[$];
    int          mismatches;
    int          items_sent;
    bit          quiet;
    bit          hold_req;
    int          idle_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int used_cap();
        if (cap_reg < 1) return 1;
        if (cap_reg > NODES) return NODES;
        return int'(cap_reg);
    endfunction

    function automatic void graph_clear();
        foreach (reach[n]) reach[n] = 1'b0;
        reach[0] = 1'b1;
        foreach (marks[i, n]) marks[i][n] = 1'b0;
        foreach (wts[i]) wts[i] = 0;
        n_items   = 0;
        phase     = PH_LOAD;
        cur_item  = 0;
        cur_node  = 0;
        last_load = 0;
    endfunction

    function automatic logic [1:0] graph_add(int w, int d);
        int c;
        int it;
        int head;
        c = used_cap();
        if (w == 0 || phase != PH_LOAD || n_items >= ITEM_SLOTS) return ST_REJ;
        it = n_items;
        wts[it] = w;
        for (int n = 0; n <= NODES; n++) marks[it][n] = 1'b0;
        if (w <= c)
        begin
            // descending start loads so new heads are not reused by this item
            for (int j = c - w; j >= 0; j--)
            begin
                if (!reach[j]) continue;
                for (int k = 1; k <= d; k++)
                begin
                    head = j + k * w;
                    if (head > c) break;
                    reach[head] = 1'b1;
                    marks[it][head - w] = 1'b1;
                end
            end
        end
        n_items = it + 1;
        return ST_OK;
    endfunction

    function automatic arc_result_t graph_pull();
        arc_result_t r;
        int c;
        int t;
        int n;
        c = used_cap();
        r = '0;
        if (phase == PH_LOAD)
        begin
            phase = PH_ITEMS;
            cur_item = 0;
            cur_node = 0;
        end
        // item arcs, item order then ascending tail
        if (phase == PH_ITEMS)
        begin
            while (cur_item < n_items)
            begin
                while (cur_node <= NODES)
                begin
                    t = cur_node;
                    cur_node++;
                    if (marks[cur_item][t] && t + wts[cur_item] <= c)
                    begin
                        r.status = ST_ARC;
                        r.tail   = t[NODE_W-1:0];
                        r.head   = NODE_W'(t + wts[cur_item]);
                        r.idx    = cur_item[IDX_W-1:0];
                        return r;
                    end
                end
                cur_item++;
                cur_node = 0;
            end
            phase = PH_LOSS;
            cur_node = 1;
            last_load = 0;
        end
        // loss arcs between consecutive reachable loads
        if (phase == PH_LOSS)
        begin
            while (cur_node <= c)
            begin
                n = cur_node;
                cur_node++;
                if (!reach[n]) continue;
                if (last_load != 0)
                begin
                    r.status = ST_ARC;
                    r.tail   = last_load[NODE_W-1:0];
                    r.head   = n[NODE_W-1:0];
                    r.loss   = 1'b1;
                    last_load = n;
                    return r;
                end
                last_load = n;
            end
            phase = PH_DONE;
        end
        r.status = ST_END;
        return r;
    endfunction

    function automatic arc_result_t graph_predict(logic [1:0] c, int w, int d);
        arc_result_t r;
        r = '0;
        case (c)
            CMD_ADD:   r.status = graph_add(w, d);
            CMD_PULL:  r = graph_pull();
            CMD_CLEAR: graph_clear();
            default:   r.status = ST_REJ;
        endcase
        return r;
    endfunction

    // send one item, called and returning at a falling edge
    task automatic send_item(logic [1:0] c, int w, int d);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        cmd      = c;
        weight   = w[NODE_W-1:0];
        demand   = d[DEM_W-1:0];
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        // predict from the field bits actually driven
        arc_expect_q = {arc_expect_q, graph_predict(c, int'(weight), int'(demand))};
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (arc_expect_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_capacity(int v);
        wait_drained();
        cfg_wdata = v[NODE_W-1:0];
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        cap_reg   = v[NODE_W-1:0];
    endtask

    task automatic pull_to_end(int max_pulls);
        for (int i = 0; i < max_pulls && phase != PH_DONE; i++)
            send_item(CMD_PULL, $urandom, $urandom);
        send_item(CMD_PULL, $urandom, $urandom);
    endtask

    // transfer check at the rising edge
    always @(posedge clk)
    begin
        arc_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (arc_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result status=%0d tail=%0d head=%0d",
                             status, arc_tail, arc_head);
            end
            else
            begin
                exp_r = arc_expect_q.pop_front();
                if (status !== exp_r.status || arc_tail !== exp_r.tail ||
                    arc_head !== exp_r.head || item_index !== exp_r.idx ||
                    is_loss !== exp_r.loss)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                 exp_r.status, exp_r.tail, exp_r.head, exp_r.idx,
                                 exp_r.loss, status, arc_tail, arc_head,
                                 item_index, is_loss);
                end
            end
        end
    end

    // receiver stall bursts and the long hold-off
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                for (int i = 0; i < HOLD_LEN; i++) @(negedge clk);
                hold_req = 1'b0;
                out_stall = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("arc_flow_graph_builder_tb NOT OK");
                $finish;
            end
        end
    end

    // extremes of fields, every command and the special cases
    task automatic test_directed();
        send_item(CMD_ADD, 0, 5);
        send_item(CMD_ADD, 2047, 65535);
        send_item(CMD_ADD, 1024, 1);
        send_item(CMD_BAD, 1365, 43690);
        write_capacity(10);
        send_item(CMD_CLEAR, 682, 21845);
        send_item(CMD_ADD, 3, 2);
        send_item(CMD_ADD, 4, 65535);
        send_item(CMD_ADD, 11, 3);
        send_item(CMD_ADD, 5, 0);
        send_item(CMD_ADD, 10, 1);
        pull_to_end(14);
        send_item(CMD_ADD, 2, 2);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_PULL, 0, 0);
        send_item(CMD_PULL, 0, 0);
    endtask

    // capacity extremes and change of capacity after adds
    task automatic test_capacity();
        write_capacity(0);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_ADD, 1, 3);
        pull_to_end(4);
        write_capacity(2047);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_ADD, 1000, 2);
        send_item(CMD_ADD, 24, 1);
        pull_to_end(8);
        write_capacity(20);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_ADD, 3, 9);
        send_item(CMD_ADD, 7, 2);
        write_capacity(8);
        pull_to_end(30);
    endtask

    // item table full
    task automatic test_table_full();
        write_capacity(1);
        send_item(CMD_CLEAR, 0, 0);
        for (int i = 0; i <= ITEM_SLOTS; i++)
            send_item(CMD_ADD, $urandom_range(1, 2), $urandom_range(0, 3));
        pull_to_end(10);
    endtask

    // receiver holds off while pulls keep coming
    task automatic test_backpressure();
        write_capacity(1024);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_ADD, 1, 65535);
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_item(CMD_PULL, 0, 0);
        send_item(CMD_CLEAR, 0, 0);
    endtask

    // random well-formed sets with some noise
    task automatic test_random(int target);
        int c;
        int r;
        int w;
        while (items_sent < target)
        begin
            r = $urandom_range(0, 19);
            c = (r == 0) ? 1024 : (r == 1) ? $urandom_range(0, 2047) :
                $urandom_range(1, 48);
            write_capacity(c);
            send_item(CMD_CLEAR, $urandom, $urandom);
            for (int i = $urandom_range(1, 6); i > 0; i--)
            begin
                r = $urandom_range(0, 9);
                w = (r == 0) ? $urandom_range(0, 2047) : (r == 1) ? used_cap() :
                    $urandom_range(1, used_cap());
                r = $urandom_range(0, 5);
                send_item(CMD_ADD, w, (r == 0) ? $urandom_range(0, 65535) :
                                      $urandom_range(0, 6));
                if ($urandom_range(0, 9) == 0)
                    send_item(CMD_BAD, $urandom, $urandom);
            end
            for (int i = 0; i < 60 && phase != PH_DONE; i++)
            begin
                r = $urandom_range(0, 29);
                if (r == 0)
                    send_item(CMD_ADD, $urandom_range(0, 2047), $urandom);
                else if (r == 1)
                    send_item(CMD_BAD, $urandom, $urandom);
                else
                    send_item(CMD_PULL, $urandom, $urandom);
            end
            send_item(CMD_PULL, $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        cmd         = CMD_ADD;
        weight      = '0;
        demand      = '0;
        mismatches  = 0;
        items_sent  = 0;
        quiet       = 1'b0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        cap_reg     = 11'd1024;
        graph_clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_capacity();
        test_table_full();
        test_backpressure();
        test_random(480);
        quiet = 1'b1;
        test_random(540);

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("arc_flow_graph_builder_tb OK");
        else
            $display("arc_flow_graph_builder_tb NOT OK");
        $finish;
    end

endmodule
